// ===== rtl/lcdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdsr_pkg
// Shared types, constants, microcode table and beat formatting for the
// character LCD shadow refresher.
// ----------------------------------------------------------------------------
package lcdsr_pkg;

  // Expander byte layout: bit0 RS, bit2 EN, bit3 backlight, bits 7..4 nibble
  localparam logic [7:0] BIT_RS      = 8'h01;
  localparam logic [7:0] BIT_EN      = 8'h04;
  localparam logic [7:0] BIT_BL      = 8'h08;
  localparam logic [7:0] NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] SET_ADDR    = 8'h80;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] BLANK_CELL  = 8'h00;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_RAW     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKLIGHT = 1'b0,
    CFG_STROBE    = 1'b1
  } cfg_idx_t;

  // Microcode
  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_WRITE  = 4'd1;
  localparam step_t STEP_CLEAR  = 4'd2;
  localparam step_t STEP_RAW    = 4'd3;
  localparam step_t STEP_START  = 4'd4;
  localparam step_t STEP_CMP    = 4'd5;
  localparam step_t STEP_ADDR   = 4'd6;
  localparam step_t STEP_DATA   = 4'd7;
  localparam step_t STEP_FLUSH  = 4'd8;
  localparam step_t STEP_SKIP   = 4'd9;
  localparam step_t STEP_FLUSH2 = 4'd10;
  localparam step_t STEP_COUNT  = 4'd11;

  typedef enum logic [3:0] {
    OP_IDLE  = 4'd0,
    OP_WRITE = 4'd1,
    OP_CLEAR = 4'd2,
    OP_RAW   = 4'd3,
    OP_START = 4'd4,
    OP_NONE  = 4'd5,
    OP_ADDR  = 4'd6,
    OP_DATA  = 4'd7,
    OP_SKIP  = 4'd8,
    OP_FLUSH = 4'd9
  } op_t;

  // Conditional jumps go to target when true, else to the next step
  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_JUMP     = 3'd1,
    C_DISPATCH = 3'd2,
    C_ROW_BAD  = 3'd3,
    C_SAME     = 3'd4,
    C_MORE     = 3'd5
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:   w = '{op: OP_IDLE,  cond: C_DISPATCH, target: STEP_IDLE};
      STEP_WRITE:  w = '{op: OP_WRITE, cond: C_JUMP,     target: STEP_IDLE};
      STEP_CLEAR:  w = '{op: OP_CLEAR, cond: C_JUMP,     target: STEP_IDLE};
      STEP_RAW:    w = '{op: OP_RAW,   cond: C_JUMP,     target: STEP_IDLE};
      STEP_START:  w = '{op: OP_START, cond: C_ROW_BAD,  target: STEP_IDLE};
      STEP_CMP:    w = '{op: OP_NONE,  cond: C_SAME,     target: STEP_SKIP};
      STEP_ADDR:   w = '{op: OP_ADDR,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_DATA:   w = '{op: OP_DATA,  cond: C_MORE,     target: STEP_CMP};
      STEP_FLUSH:  w = '{op: OP_FLUSH, cond: C_JUMP,     target: STEP_IDLE};
      STEP_SKIP:   w = '{op: OP_SKIP,  cond: C_MORE,     target: STEP_CMP};
      STEP_FLUSH2: w = '{op: OP_FLUSH, cond: C_JUMP,     target: STEP_IDLE};
      default:     w = '{op: OP_NONE,  cond: C_JUMP,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t dispatch_step(input cmd_t cmd);
    step_t s;
    unique case (cmd)
      CMD_WRITE:   s = STEP_WRITE;
      CMD_REFRESH: s = STEP_START;
      CMD_CLEAR:   s = STEP_CLEAR;
      CMD_RAW:     s = STEP_RAW;
      default:     s = STEP_IDLE;
    endcase
    return s;
  endfunction

  // DDRAM row offsets of the 20x4 map
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [7:0] byte_fourth;
    logic       is_data;
    logic       last;
  } beat_t;

  function automatic beat_t make_beat(input logic [7:0] value, input logic data,
                                      input logic last, input logic bl,
                                      input logic stb);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] flags;
    logic [7:0] light;
    logic [7:0] strobe;
    beat_t      b;
    hi     = value & NIBBLE_MASK;
    lo     = {value[3:0], 4'h0};
    flags  = data ? BIT_RS : 8'h00;
    light  = bl ? BIT_BL : 8'h00;
    strobe = stb ? BIT_EN : BIT_RS;
    b.byte_first  = hi | flags | light | strobe;
    b.byte_second = hi | flags | light;
    b.byte_third  = lo | flags | light | strobe;
    b.byte_fourth = lo | flags | light;
    b.is_data     = data;
    b.last        = last;
    return b;
  endfunction

endpackage

// ===== rtl/lcdsr_in_if.sv =====
// ----------------------------------------------------------------------------
// lcdsr_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface lcdsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] row;
  logic [6:0] column;
  logic [7:0] char_code;

  modport source (output valid, command, row, column, char_code, input ready);
  modport sink   (input valid, command, row, column, char_code, output ready);
endinterface

// ===== rtl/lcdsr_out_if.sv =====
// ----------------------------------------------------------------------------
// lcdsr_out_if
// Transfer channel: valid/ready handshake with four expander bytes per beat.
// ----------------------------------------------------------------------------
interface lcdsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [7:0] byte_fourth;
  logic       is_data;
  logic       last;

  modport source (output valid, byte_first, byte_second, byte_third, byte_fourth,
                  is_data, last, input ready);
  modport sink   (input valid, byte_first, byte_second, byte_third, byte_fourth,
                  is_data, last, output ready);
endinterface

// ===== rtl/lcdsr_ram.sv =====
// ----------------------------------------------------------------------------
// lcdsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcdsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/char_lcd_shadow_refresh.sv =====
// ----------------------------------------------------------------------------
// char_lcd_shadow_refresh
// Wanted/shown shadow buffers for a text LCD driven in 4-bit mode through a
// port expander; a refresh sends only the changed cells of one row.
// ----------------------------------------------------------------------------
// Sequence: write cell, clear and raw instruction take the accept and one
//   microcode step; the raw beat enters the output register in that step,
//   which holds while that register is full. Refresh: accept, start step,
//   per cell a compare step then skip (unchanged) or address and data steps
//   (changed), a flush step for the last beat; held while the output stalls.
// Reset: config back to backlight on / strobe on; per-cell valid flops clear
//   at once, so wanted reads as spaces and shown as zero. No clearing pass.
// ----------------------------------------------------------------------------
module char_lcd_shadow_refresh #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lcdsr_in_if.sink                      in_ch,
  lcdsr_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [lcdsr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic                          cfg_wdata
);
  import lcdsr_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  // wide enough for row*COLUMNS + column with any 2-bit row, 7-bit column
  localparam int IDX_W = $clog2(3 * COLUMNS + 128);

  // sequencer
  step_t  step_r, step_nxt;
  ucode_t uc;
  logic   stall;

  // latched command fields
  logic [1:0] row_r, row_nxt;
  logic [6:0] column_r, column_nxt;
  logic [7:0] char_r, char_nxt;

  // refresh walk
  logic [CW-1:0] col_r, col_nxt;
  logic          run_r, run_nxt;     // inside a run of changed cells

  // one-beat hold so the final beat of a refresh can carry last
  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_val_r, pend_val_nxt;
  logic       pend_data_r, pend_data_nxt;

  // output register
  logic  out_valid_r, out_valid_nxt;
  beat_t out_beat_r, out_beat_nxt;
  logic  slot_free;

  // config
  logic backlight_r, strobe_r;

  // per-cell valid flops (invalid wanted reads as space, invalid shown as zero)
  logic [CELLS-1:0] wv_r, wv_nxt;
  logic [CELLS-1:0] sv_r, sv_nxt;
  logic             wv_q_r, sv_q_r;

  // RAM ports
  logic           wram_we, sram_we, ram_re;
  logic [AW-1:0]  wram_waddr, rd_addr, cell_addr;
  logic [7:0]     wram_q, sram_q;

  // datapath terms
  logic [IDX_W-1:0] cell_idx, wr_idx, rd_idx, row_off;
  logic [7:0]       wanted_cell, shown_cell, addr_byte;
  logic             same, last_col, row_bad;
  beat_t            pend_beat;

  lcdsr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_wanted (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (char_r),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (wram_q)
  );

  lcdsr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_shown (
    .clk   (clk),
    .we    (sram_we),
    .waddr (cell_addr),
    .wdata (wanted_cell),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (sram_q)
  );

  assign in_ch.ready        = (step_r == STEP_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_first  = out_beat_r.byte_first;
  assign out_ch.byte_second = out_beat_r.byte_second;
  assign out_ch.byte_third  = out_beat_r.byte_third;
  assign out_ch.byte_fourth = out_beat_r.byte_fourth;
  assign out_ch.is_data     = out_beat_r.is_data;
  assign out_ch.last        = out_beat_r.last;

  always_comb begin
    uc        = ucode_rom(step_r);
    slot_free = !out_valid_r || out_ch.ready;

    row_off   = IDX_W'(row_r) * IDX_W'(COLUMNS);
    cell_idx  = row_off + IDX_W'(col_r);
    cell_addr = cell_idx[AW-1:0];
    wr_idx    = row_off + IDX_W'(column_r);
    rd_idx    = (uc.op == OP_START) ? row_off : cell_idx + IDX_W'(1);
    rd_addr   = rd_idx[AW-1:0];

    wanted_cell = wv_q_r ? wram_q : SPACE_CHAR;
    shown_cell  = sv_q_r ? sram_q : BLANK_CELL;
    same        = (wanted_cell == shown_cell);
    last_col    = (col_r == CW'(COLUMNS - 1));
    row_bad     = ({1'b0, row_r} >= 3'(ROWS));
    addr_byte   = SET_ADDR | {1'b0, 7'(row_base(row_r) + 8'(col_r))};
    pend_beat   = make_beat(pend_val_r, pend_data_r, 1'b0, backlight_r, strobe_r);

    // idle holds until a command arrives; other steps hold when they must hand a beat to a full output register
    unique case (uc.op)
      OP_IDLE:           stall = !in_ch.valid;
      OP_RAW:            stall = !slot_free;
      OP_ADDR:           stall = !run_r && pend_valid_r && !slot_free;
      OP_DATA, OP_FLUSH: stall = pend_valid_r && !slot_free;
      default:           stall = 1'b0;
    endcase

    step_nxt       = step_r;
    row_nxt        = row_r;
    column_nxt     = column_r;
    char_nxt       = char_r;
    col_nxt        = col_r;
    run_nxt        = run_r;
    pend_valid_nxt = pend_valid_r;
    pend_val_nxt   = pend_val_r;
    pend_data_nxt  = pend_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_beat_nxt   = out_beat_r;
    wv_nxt         = wv_r;
    sv_nxt         = sv_r;
    wram_we        = 1'b0;
    wram_waddr     = wr_idx[AW-1:0];
    sram_we        = 1'b0;
    ram_re         = 1'b0;

    if (!stall) begin
      unique case (uc.op)
        OP_IDLE: begin
          row_nxt    = in_ch.row;
          column_nxt = in_ch.column;
          char_nxt   = in_ch.char_code;
        end
        OP_WRITE: begin
          if (wr_idx < IDX_W'(CELLS)) begin
            wram_we                = 1'b1;
            wv_nxt[wr_idx[AW-1:0]] = 1'b1;
          end
        end
        OP_CLEAR: wv_nxt = '0;
        OP_RAW: begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = make_beat(char_r, 1'b0, 1'b1, backlight_r, strobe_r);
        end
        OP_START: begin
          col_nxt = '0;
          run_nxt = 1'b0;
          ram_re  = !row_bad;
        end
        OP_ADDR: begin
          // set-address opens a run of changed cells
          if (!run_r) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_beat_nxt  = pend_beat;
            end
            pend_valid_nxt = 1'b1;
            pend_val_nxt   = addr_byte;
            pend_data_nxt  = 1'b0;
          end
        end
        OP_DATA: begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_beat_nxt  = pend_beat;
          end
          pend_valid_nxt    = 1'b1;
          pend_val_nxt      = wanted_cell;
          pend_data_nxt     = 1'b1;
          sram_we           = 1'b1;
          sv_nxt[cell_addr] = 1'b1;
          run_nxt           = 1'b1;
          if (!last_col) begin
            col_nxt = col_r + CW'(1);
            ram_re  = 1'b1;
          end
        end
        OP_SKIP: begin
          run_nxt = 1'b0;
          if (!last_col) begin
            col_nxt = col_r + CW'(1);
            ram_re  = 1'b1;
          end
        end
        OP_FLUSH: begin
          if (pend_valid_r) begin
            out_valid_nxt   = 1'b1;
            out_beat_nxt    = pend_beat;
            out_beat_nxt.last = 1'b1;
            pend_valid_nxt  = 1'b0;
          end
        end
        default: ;
      endcase

      unique case (uc.cond)
        C_NEXT:     step_nxt = step_r + step_t'(1);
        C_JUMP:     step_nxt = uc.target;
        C_DISPATCH: step_nxt = dispatch_step(cmd_t'(in_ch.command));
        C_ROW_BAD:  step_nxt = row_bad ? uc.target : step_r + step_t'(1);
        C_SAME:     step_nxt = same ? uc.target : step_r + step_t'(1);
        C_MORE:     step_nxt = !last_col ? uc.target : step_r + step_t'(1);
        default:    step_nxt = STEP_IDLE;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= STEP_IDLE;
      run_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      wv_r         <= '0;
      sv_r         <= '0;
      col_r        <= '0;
    end else begin
      step_r       <= step_nxt;
      run_r        <= run_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      wv_r         <= wv_nxt;
      sv_r         <= sv_nxt;
      col_r        <= col_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    column_r    <= column_nxt;
    char_r      <= char_nxt;
    pend_val_r  <= pend_val_nxt;
    pend_data_r <= pend_data_nxt;
    out_beat_r  <= out_beat_nxt;
    if (ram_re) begin
      wv_q_r <= wv_r[rd_addr];
      sv_q_r <= sv_r[rd_addr];
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b1;
      strobe_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_BACKLIGHT: backlight_r <= cfg_wdata;
        CFG_STROBE:    strobe_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // held beat never survives back to idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_IDLE |-> !pend_valid_r)
    else $error("pending beat left over in idle");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(COLUMNS - 1))
    else $error("column counter out of range");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < STEP_COUNT)
    else $error("step counter outside microcode");

  // data step is only reached for a changed cell, and read data must hold
  a_data_changed: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_DATA |-> !same)
    else $error("data beat for an unchanged cell");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.op == OP_FLUSH && pend_valid_r && slot_free) |=> (out_valid_r && out_beat_r.last))
    else $error("flush did not mark last");

endmodule
